>>> design/prtb_pkg.sv
`default_nettype none

package prtb_pkg;

  localparam int MAX_RESULTS = 16;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_CONFIG = 1'b1;

  typedef struct packed {
    logic [7:0]  setting;
    logic [7:0]  phase;
    logic [15:0] count;
    logic [15:0] reload;
    logic        notify;
  } timer_entry_t;

  typedef struct packed {
    logic start;
    logic cfg_wr;
    logic advance;
    logic flush;
  } prtb_cmd_t;

  typedef struct packed {
    logic blocked;
    logic at_last;
    logic flush_ok;
  } prtb_sts_t;

endpackage

`default_nettype wire

>>> design/prtb_ctrl.sv
`default_nettype none

module prtb_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  input  wire logic                in_op,
  output logic                     in_tready,
  input  wire prtb_pkg::prtb_sts_t sts,
  output prtb_pkg::prtb_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_VISIT = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd.start   = 1'b0;
    cmd.cfg_wr  = 1'b0;
    cmd.advance = 1'b0;
    cmd.flush   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_op == prtb_pkg::OP_CONFIG) begin
            cmd.cfg_wr = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = ST_VISIT;
          end
        end
      end
      ST_VISIT: begin
        if (!sts.blocked) begin
          cmd.advance = 1'b1;
          if (sts.at_last) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (sts.flush_ok) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/prtb_dp.sv
`default_nettype none

module prtb_dp #(
  parameter int NUM_TIMERS     = 16,
  parameter int QUEUE_CAPACITY = 64,
  parameter int BASE_RATE_HZ   = 60
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire prtb_pkg::prtb_cmd_t cmd,
  output prtb_pkg::prtb_sts_t      sts,
  input  wire logic [3:0]          in_timer_index,
  input  wire logic [7:0]          in_prescale,
  input  wire logic [15:0]         in_reload_count,
  input  wire logic                in_notify_enable,
  input  wire logic [15:0]         in_start_value,
  input  wire logic [6:0]          in_queue_level,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [3:0]               out_expired_index,
  output logic [63:0]              out_tick_stamp,
  output logic                     out_last
);

  localparam int IW    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int HALF  = QUEUE_CAPACITY / 2;
  localparam int LVL_W = ($clog2(HALF + 1) > 8) ? $clog2(HALF + 1) : 8;
  localparam logic [7:0] RST_SETTING = 8'(BASE_RATE_HZ / 10);
  localparam prtb_pkg::timer_entry_t RST_ENT = '{
    setting: RST_SETTING, phase: 8'd1, count: 16'd0, reload: 16'd0, notify: 1'b0};

  prtb_pkg::timer_entry_t mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]  valid_r;
  prtb_pkg::timer_entry_t rd_data_r;
  logic                   rd_valid_r;

  logic [IW-1:0] idx_r;
  logic [63:0]   ticks_r;
  logic [6:0]    base_r;
  logic [4:0]    emitted_r;
  logic          pend_v_r;
  logic [3:0]    pend_idx_r;

  logic          out_valid_r;
  logic [3:0]    out_idx_r;
  logic [63:0]   out_stamp_r;
  logic          out_last_r;

  prtb_pkg::timer_entry_t ent;
  prtb_pkg::timer_entry_t ent_nxt;
  prtb_pkg::timer_entry_t cfg_ent;
  logic [IW-1:0]  rd_addr;
  logic [IW-1:0]  cfg_addr;
  logic           cfg_hit;
  logic           running;
  logic [7:0]     ph1;
  logic [15:0]    c1;
  logic           expire;
  logic [LVL_W-1:0] level;
  logic           drop;
  logic           rec;
  logic           out_free;
  logic           out_load;
  logic           wr_en;
  logic [IW-1:0]  wr_addr;
  prtb_pkg::timer_entry_t wr_data;

  assign ent      = rd_valid_r ? rd_data_r : RST_ENT;
  assign running  = (ent.count != 16'd0);
  assign ph1      = ent.phase - 8'd1;
  assign c1       = ent.count - 16'd1;
  assign expire   = running && (ph1 == 8'd0) && (c1 == 16'd0);
  assign level    = LVL_W'(base_r) + LVL_W'(emitted_r);
  assign drop     = (ent.reload != 16'd0) && (level > LVL_W'(HALF));
  assign rec      = expire && ent.notify && !drop &&
                    (emitted_r < 5'(prtb_pkg::MAX_RESULTS));
  assign out_free = !out_valid_r || out_ready;
  assign out_load = (cmd.advance && rec && pend_v_r) || (cmd.flush && pend_v_r);

  always_comb begin
    ent_nxt = ent;
    if (running) begin
      ent_nxt.phase = ph1;
      if (ph1 == 8'd0) begin
        ent_nxt.phase = ent.setting;
        ent_nxt.count = (c1 == 16'd0) ? ent.reload : c1;
      end
    end
  end

  assign sts.blocked  = rec && pend_v_r && !out_free;
  assign sts.at_last  = (idx_r == IW'(NUM_TIMERS - 1));
  assign sts.flush_ok = !pend_v_r || out_free;

  assign cfg_addr = IW'(in_timer_index);
  assign cfg_hit  = (32'(in_timer_index) < NUM_TIMERS);
  assign cfg_ent  = '{setting: in_prescale, phase: 8'd1, count: in_start_value,
                      reload: in_reload_count, notify: in_notify_enable};

  always_comb begin
    if (cmd.start) begin
      rd_addr = '0;
    end else if (cmd.advance) begin
      rd_addr = idx_r + IW'(1);
    end else begin
      rd_addr = idx_r;
    end
  end

  assign wr_en   = (cmd.cfg_wr && cfg_hit) || cmd.advance;
  assign wr_addr = cmd.cfg_wr ? cfg_addr : idx_r;
  assign wr_data = cmd.cfg_wr ? cfg_ent : ent_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      ticks_r     <= 64'd0;
      base_r      <= 7'd0;
      emitted_r   <= 5'd0;
      pend_v_r    <= 1'b0;
      pend_idx_r  <= 4'd0;
      out_valid_r <= 1'b0;
      out_idx_r   <= 4'd0;
      out_stamp_r <= 64'd0;
      out_last_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.start) begin
        idx_r     <= '0;
        ticks_r   <= ticks_r + 64'd1;
        base_r    <= in_queue_level;
        emitted_r <= 5'd0;
      end
      if (cmd.advance) begin
        idx_r <= idx_r + IW'(1);
        if (rec) begin
          emitted_r  <= emitted_r + 5'd1;
          pend_v_r   <= 1'b1;
          pend_idx_r <= 4'(idx_r);
          if (pend_v_r) begin
            out_idx_r   <= pend_idx_r;
            out_stamp_r <= ticks_r;
            out_last_r  <= 1'b0;
          end
        end
      end
      if (cmd.flush && pend_v_r) begin
        pend_v_r    <= 1'b0;
        out_idx_r   <= pend_idx_r;
        out_stamp_r <= ticks_r;
        out_last_r  <= 1'b1;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_expired_index = out_idx_r;
  assign out_tick_stamp    = out_stamp_r;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire

>>> design/prescaled_reload_timer_bank.sv
// Bank of prescaled auto-reload countdown timers.
// Input stream: in_tuser selects the operation (tick or configure), in_tdata
// carries the timer fields and the downstream queue level. A configure
// transfer loads one timer and produces nothing.
// A tick transfer bumps the 64-bit tick counter and then walks the timers one
// per cycle, unless stalled on the output, through the timer memory's single
// read port: accept, one visit per timer, then a final flush. in_tready is low
// while a tick is in progress. Output stream: one transfer per expiration
// record, tlast on the last record of the tick. Each record is held one
// visit back until the next one is found so tlast can be known. When
// out_tready is low and a second record is pending, the timer walk waits;
// no record is lost.
// Reset: all timers stopped, reload zero, prescale BASE_RATE_HZ/10, phase one,
// tick counter zero. Timer state resets through per-entry valid bits, so the
// block takes transfers in the first cycle after reset.
`default_nettype none

module prescaled_reload_timer_bank #(
  parameter int NUM_TIMERS     = 16,
  parameter int QUEUE_CAPACITY = 64,
  parameter int BASE_RATE_HZ   = 60
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // timer_index[3:0], prescale[11:4], reload_count[27:12], notify_enable[28],
  // start_value[44:29], queue_level[51:45], zero pad [55:52]
  input  wire logic [55:0] in_tdata,
  // operation[0]
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // expired_index[3:0], tick_stamp[67:4], zero pad [71:68]
  output logic [71:0]      out_tdata,
  output logic             out_tlast
);

  prtb_pkg::prtb_cmd_t cmd;
  prtb_pkg::prtb_sts_t sts;
  logic [3:0]  exp_idx;
  logic [63:0] stamp;

  prtb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  prtb_dp #(
    .NUM_TIMERS     (NUM_TIMERS),
    .QUEUE_CAPACITY (QUEUE_CAPACITY),
    .BASE_RATE_HZ   (BASE_RATE_HZ)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_timer_index    (in_tdata[3:0]),
    .in_prescale       (in_tdata[11:4]),
    .in_reload_count   (in_tdata[27:12]),
    .in_notify_enable  (in_tdata[28]),
    .in_start_value    (in_tdata[44:29]),
    .in_queue_level    (in_tdata[51:45]),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .out_expired_index (exp_idx),
    .out_tick_stamp    (stamp),
    .out_last          (out_tlast)
  );

  assign out_tdata = {4'd0, stamp, exp_idx};

endmodule

`default_nettype wire
